[hdl/ugb_pkg.sv]
// ----------------------------------------------------------------------------
// ugb_pkg
// Shared types, codes and constants of the uniform grid box broadphase.
// ----------------------------------------------------------------------------
package ugb_pkg;

  // field widths
  localparam int COORD_W    = 24;
  localparam int TAG_W      = 32;
  localparam int ID_W       = 6;
  localparam int ACT_W      = 2;
  localparam int KIND_W     = 3;
  localparam int SIZE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // entry store holds every id the 6 bit field can name
  localparam int ENTRY_DEPTH = 1 << ID_W;

  // divider dividend width (magnitude of whole units) and signed tile coordinate width
  localparam int DIV_DW = 18;
  localparam int TILE_W = DIV_DW + 1;

  // default layout
  localparam int TILES_X_DEF        = 8;
  localparam int TILES_Y_DEF        = 8;
  localparam int SLOTS_PER_TILE_DEF = 8;
  localparam int MAX_ENTRIES_DEF    = 63;

  // register reset values
  localparam logic [SIZE_W-1:0] GRID_W_RST = 16'd128;
  localparam logic [SIZE_W-1:0] GRID_H_RST = 16'd128;
  localparam logic [SIZE_W-1:0] TILE_S_RST = 16'd16;

  // actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE   = 3'd4;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED = 3'd0,
    KIND_HIT      = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_OOB      = 3'd3,
    KIND_FULL     = 3'd4,
    KIND_CLEARED  = 3'd5
  } kind_t;

  // one stored box
  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic  in_ready;
    logic  load;
    logic  clr_grid;
    logic  div_start;
    logic  div_capture;
    logic  walk_init;
    logic  walk_next;
    logic  fill_rd;
    logic  fill_latch;
    logic  ins_entry;
    logic  ins_wr;
    logic  seen_clr;
    logic  slot_rd;
    logic  ent_rd;
    logic  seen_set;
    logic  set_kind;
    kind_t kind;
    logic  out_load;
    logic  out_hit;
  } ugb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             in_valid;
    logic [ACT_W-1:0] act;
    logic             is_insert;
    logic             ts_zero;
    logic             div_busy;
    logic             div_done;
    logic             div_last;
    logic             oob;
    logic             id_full;
    logic             walk_empty;
    logic             walk_last;
    logic             fill_full;
    logic             slot_end;
    logic             hit;
    logic             out_free;
  } ugb_stat_t;

endpackage

[hdl/ugb_in_if.sv]
// ----------------------------------------------------------------------------
// ugb_in_if
// Input item channel: action, box corners and tag.
// ----------------------------------------------------------------------------
interface ugb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [23:0] box_min_x;
  logic signed [23:0] box_min_y;
  logic signed [23:0] box_max_x;
  logic signed [23:0] box_max_y;
  logic [31:0]        tag;

  modport source (output valid, action, box_min_x, box_min_y, box_max_x, box_max_y, tag,
                  input ready);
  modport sink (input valid, action, box_min_x, box_min_y, box_max_x, box_max_y, tag,
                output ready);
endinterface

[hdl/ugb_out_if.sv]
// ----------------------------------------------------------------------------
// ugb_out_if
// Result item channel: kind, id and the stored box of a hit.
// ----------------------------------------------------------------------------
interface ugb_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [5:0]         entry_id;
  logic signed [23:0] hit_min_x;
  logic signed [23:0] hit_min_y;
  logic signed [23:0] hit_max_x;
  logic signed [23:0] hit_max_y;
  logic [31:0]        hit_tag;
  logic               last;

  modport source (output valid, kind, entry_id, hit_min_x, hit_min_y, hit_max_x,
                  hit_max_y, hit_tag, last, input ready);
  modport sink (input valid, kind, entry_id, hit_min_x, hit_min_y, hit_max_x,
                hit_max_y, hit_tag, last, output ready);
endinterface

[hdl/ugb_div.sv]
// ----------------------------------------------------------------------------
// ugb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ugb_div import ugb_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int VW = SIZE_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [VW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   shifted;
  logic [VW+1:0] diff;

  // trial subtract of the next partial remainder
  assign shifted = {rem_r, quo_r[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  // iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= diff[VW+1] ? shifted[VW-1:0] : diff[VW-1:0];
      quo_r <= {quo_r[DW-2:0], ~diff[VW+1]};
    end
  end

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/ugb_datapath.sv]
// ----------------------------------------------------------------------------
// ugb_datapath
// Registers, tile and entry memories, tile divider, compare and result register.
// ----------------------------------------------------------------------------
module ugb_datapath import ugb_pkg::*; #(
  parameter int TILES_X        = TILES_X_DEF,
  parameter int TILES_Y        = TILES_Y_DEF,
  parameter int SLOTS_PER_TILE = SLOTS_PER_TILE_DEF,
  parameter int MAX_ENTRIES    = MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_valid,
  input  logic [ACT_W-1:0]          in_action,
  input  logic signed [COORD_W-1:0] in_box_min_x,
  input  logic signed [COORD_W-1:0] in_box_min_y,
  input  logic signed [COORD_W-1:0] in_box_max_x,
  input  logic signed [COORD_W-1:0] in_box_max_y,
  input  logic [TAG_W-1:0]          in_tag,
  input  ugb_cmd_t                  cmd,
  output ugb_stat_t                 stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output kind_t                     out_kind,
  output logic [ID_W-1:0]           out_entry_id,
  output logic signed [COORD_W-1:0] out_hit_min_x,
  output logic signed [COORD_W-1:0] out_hit_min_y,
  output logic signed [COORD_W-1:0] out_hit_max_x,
  output logic signed [COORD_W-1:0] out_hit_max_y,
  output logic [TAG_W-1:0]          out_hit_tag,
  output logic                      out_last
);

  localparam int NT  = TILES_X * TILES_Y;
  localparam int TAW = (NT > 1) ? $clog2(NT) : 1;
  localparam int XW  = (TILES_X > 1) ? $clog2(TILES_X) : 1;
  localparam int YW  = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
  localparam int CXW = $clog2(TILES_X + 1);
  localparam int CYW = $clog2(TILES_Y + 1);
  localparam int FW  = $clog2(SLOTS_PER_TILE + 1);
  localparam int SW  = (SLOTS_PER_TILE > 1) ? $clog2(SLOTS_PER_TILE) : 1;
  localparam int NS  = NT * SLOTS_PER_TILE;
  localparam int SAW = (NS > 1) ? $clog2(NS) : 1;

  // division order: tile counts first, then the four corners
  localparam logic [2:0] DSEL_TX = 3'd0;
  localparam logic [2:0] DSEL_TY = 3'd1;
  localparam logic [2:0] DSEL_X0 = 3'd2;
  localparam logic [2:0] DSEL_Y0 = 3'd3;
  localparam logic [2:0] DSEL_X1 = 3'd4;
  localparam logic [2:0] DSEL_Y1 = 3'd5;

  // configuration registers
  logic signed [COORD_W-1:0] org_x_r, org_y_r;
  logic [SIZE_W-1:0]         gw_r, gh_r, ts_r;

  // latched item
  logic [ACT_W-1:0]          act_r;
  logic signed [COORD_W-1:0] bmin_x_r, bmin_y_r, bmax_x_r, bmax_y_r;
  logic [TAG_W-1:0]          tag_r;

  // tile range
  logic [2:0]               div_sel_r;
  logic                     neg_r;
  logic [CXW-1:0]           tx_r;
  logic [CYW-1:0]           ty_r;
  logic signed [TILE_W-1:0] tile_x0_r, tile_y0_r, tile_x1_r, tile_y1_r;

  // walk and memories
  logic [XW-1:0]    x_r;
  logic [YW-1:0]    y_r;
  logic [TAW-1:0]   tile_addr;
  logic [FW-1:0]    fill_mem [NT];
  logic [NT-1:0]    fill_vld_r;
  logic [FW-1:0]    fill_q_r;
  logic             fill_vq_r;
  logic [FW-1:0]    fill_cur;
  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    s_r;
  logic [ID_W-1:0]  slot_mem [NS];
  logic [SAW-1:0]   slot_waddr, slot_raddr;
  logic [ID_W-1:0]  slot_q_r;
  entry_t           entry_mem [ENTRY_DEPTH];
  entry_t           entry_q_r;
  logic [ID_W-1:0]  id_r;
  logic [ID_W-1:0]  id_nxt;
  logic [ENTRY_DEPTH-1:0] seen_r;
  kind_t            kind_r;

  // result register
  logic                      out_valid_r;
  kind_t                     out_kind_r;
  logic [ID_W-1:0]           out_id_r;
  entry_t                    out_box_r;
  logic                      out_last_r;

  // divider operands
  logic signed [COORD_W-1:0] c_sel, o_sel;
  logic [SIZE_W-1:0]         s_sel;
  logic signed [25:0]        rel;
  logic [25:0]               rel_mag;
  logic                      is_corner;
  logic [DIV_DW-1:0]         dividend;
  logic                      div_busy, div_done;
  logic [DIV_DW-1:0]         div_q;
  logic signed [TILE_W-1:0]  tval;
  logic                      overlap;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      gw_r    <= GRID_W_RST;
      gh_r    <= GRID_H_RST;
      ts_r    <= TILE_S_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    org_x_r <= cfg_wdata;
        REG_ORIGIN_Y:    org_y_r <= cfg_wdata;
        REG_GRID_WIDTH:  gw_r    <= cfg_wdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: gh_r    <= cfg_wdata[SIZE_W-1:0];
        REG_TILE_SIZE:   ts_r    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      bmin_x_r <= in_box_min_x;
      bmin_y_r <= in_box_min_y;
      bmax_x_r <= in_box_max_x;
      bmax_y_r <= in_box_max_y;
      tag_r    <= in_tag;
    end
  end

  // operand select: grid size for tile counts, shifted corner otherwise
  always_comb begin
    is_corner = 1'b1;
    c_sel     = bmin_x_r;
    o_sel     = org_x_r;
    s_sel     = gw_r;
    case (div_sel_r)
      DSEL_TX: begin
        is_corner = 1'b0;
        s_sel     = gw_r;
      end
      DSEL_TY: begin
        is_corner = 1'b0;
        s_sel     = gh_r;
      end
      DSEL_X0: begin
        c_sel = bmin_x_r;
        o_sel = org_x_r;
        s_sel = gw_r;
      end
      DSEL_Y0: begin
        c_sel = bmin_y_r;
        o_sel = org_y_r;
        s_sel = gh_r;
      end
      DSEL_X1: begin
        c_sel = bmax_x_r;
        o_sel = org_x_r;
        s_sel = gw_r;
      end
      DSEL_Y1: begin
        c_sel = bmax_y_r;
        o_sel = org_y_r;
        s_sel = gh_r;
      end
      default: ;
    endcase
    rel      = 26'(c_sel) + $signed({3'b000, s_sel, 7'b0000000}) - 26'(o_sel);
    rel_mag  = rel[25] ? 26'(-rel) : 26'(rel);
    dividend = is_corner ? rel_mag[25:8] : DIV_DW'(s_sel);
  end

  ugb_div #(
    .DW (DIV_DW),
    .VW (SIZE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (ts_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // signed tile coordinate, truncated toward zero
  assign tval = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  // capture of tile counts and corner tiles
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_sel_r <= DSEL_TX;
    end else if (cmd.div_capture) begin
      div_sel_r <= div_sel_r + 3'd1;
    end
    if (cmd.div_start) begin
      neg_r <= is_corner & rel[25];
    end
    if (cmd.div_capture) begin
      case (div_sel_r)
        DSEL_TX: tx_r <= (div_q > DIV_DW'(TILES_X)) ? CXW'(TILES_X) : CXW'(div_q);
        DSEL_TY: ty_r <= (div_q > DIV_DW'(TILES_Y)) ? CYW'(TILES_Y) : CYW'(div_q);
        DSEL_X0: tile_x0_r <= tval;
        DSEL_Y0: tile_y0_r <= tval;
        DSEL_X1: tile_x1_r <= tval;
        DSEL_Y1: tile_y1_r <= tval;
        default: ;
      endcase
    end
  end

  // tile walk, x outer and y inner
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      x_r <= tile_x0_r[XW-1:0];
      y_r <= tile_y0_r[YW-1:0];
    end else if (cmd.walk_next) begin
      if (y_r == tile_y1_r[YW-1:0]) begin
        y_r <= tile_y0_r[YW-1:0];
        x_r <= x_r + 1'b1;
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
  end

  assign tile_addr = TAW'(y_r) * TAW'(TILES_X) + TAW'(x_r);

  // tile fill counts with per-tile valid bits
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      fill_mem[tile_addr] <= fill_cur + 1'b1;
    end
    if (cmd.fill_rd) begin
      fill_q_r  <= fill_mem[tile_addr];
      fill_vq_r <= fill_vld_r[tile_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r <= '0;
    end else if (cmd.clr_grid) begin
      fill_vld_r <= '0;
    end else if (cmd.ins_wr) begin
      fill_vld_r[tile_addr] <= 1'b1;
    end
  end

  assign fill_cur = fill_vq_r ? fill_q_r : '0;

  // slot store
  assign slot_waddr = SAW'(tile_addr) * SAW'(SLOTS_PER_TILE) + SAW'(fill_cur[SW-1:0]);
  assign slot_raddr = SAW'(tile_addr) * SAW'(SLOTS_PER_TILE) + SAW'(s_r[SW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      slot_mem[slot_waddr] <= id_r;
    end
    if (cmd.slot_rd) begin
      slot_q_r <= slot_mem[slot_raddr];
    end
  end

  // per-tile slot scan
  always_ff @(posedge clk) begin
    if (cmd.fill_latch) begin
      fill_r <= fill_cur;
      s_r    <= '0;
    end else if (cmd.slot_rd) begin
      s_r <= s_r + 1'b1;
    end
  end

  // entry store
  assign id_nxt = id_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.ins_entry) begin
      entry_mem[id_nxt] <= {bmin_x_r, bmin_y_r, bmax_x_r, bmax_y_r, tag_r};
    end
    if (cmd.ent_rd) begin
      entry_q_r <= entry_mem[slot_q_r];
    end
  end

  // id counter and seen marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r   <= '0;
      seen_r <= '0;
    end else begin
      if (cmd.clr_grid) begin
        id_r <= '0;
      end else if (cmd.ins_entry) begin
        id_r <= id_nxt;
      end
      if (cmd.seen_clr) begin
        seen_r <= '0;
      end else if (cmd.seen_set) begin
        seen_r[slot_q_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_kind) begin
      kind_r <= cmd.kind;
    end
  end

  // inclusive overlap of query box and stored box
  assign overlap = !(bmax_x_r < entry_q_r.min_x || entry_q_r.max_x < bmin_x_r) &&
                   !(bmax_y_r < entry_q_r.min_y || entry_q_r.max_y < bmin_y_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_hit) begin
        out_kind_r <= KIND_HIT;
        out_id_r   <= slot_q_r;
        out_box_r  <= entry_q_r;
        out_last_r <= 1'b0;
      end else begin
        out_kind_r <= kind_r;
        out_id_r   <= (kind_r == KIND_INSERTED) ? id_r : '0;
        out_box_r  <= '0;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_entry_id  = out_id_r;
  assign out_hit_min_x = out_box_r.min_x;
  assign out_hit_min_y = out_box_r.min_y;
  assign out_hit_max_x = out_box_r.max_x;
  assign out_hit_max_y = out_box_r.max_y;
  assign out_hit_tag   = out_box_r.tag;
  assign out_last      = out_last_r;

  // status to the controller
  always_comb begin
    stat.in_valid   = in_valid;
    stat.act        = in_action;
    stat.is_insert  = (act_r == ACT_INSERT);
    stat.ts_zero    = (ts_r == '0);
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.div_last   = (div_sel_r == DSEL_Y1);
    stat.oob        = tile_x0_r[TILE_W-1] || tile_y0_r[TILE_W-1] ||
                      (tile_x1_r >= $signed(TILE_W'(tx_r))) ||
                      (tile_y1_r >= $signed(TILE_W'(ty_r)));
    stat.id_full    = (id_r >= ID_W'(MAX_ENTRIES));
    stat.walk_empty = (tile_x0_r > tile_x1_r) || (tile_y0_r > tile_y1_r);
    stat.walk_last  = (x_r == tile_x1_r[XW-1:0]) && (y_r == tile_y1_r[YW-1:0]);
    stat.fill_full  = (fill_cur >= FW'(SLOTS_PER_TILE));
    stat.slot_end   = (s_r >= fill_r);
    stat.hit        = !seen_r[slot_q_r] && overlap;
    stat.out_free   = !out_valid_r || out_ready;
  end

endmodule

[hdl/ugb_ctrl.sv]
// ----------------------------------------------------------------------------
// ugb_ctrl
// Sequencer for insert, query and clear over the grid datapath.
// ----------------------------------------------------------------------------
module ugb_ctrl import ugb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ugb_stat_t stat,
  output ugb_cmd_t  cmd
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'b00000000000000001,
    S_CLEAR     = 17'b00000000000000010,
    S_DIV_GO    = 17'b00000000000000100,
    S_DIV_WAIT  = 17'b00000000000001000,
    S_CHECK     = 17'b00000000000010000,
    S_FCHK_RD   = 17'b00000000000100000,
    S_FCHK_CMP  = 17'b00000000001000000,
    S_INS_ENTRY = 17'b00000000010000000,
    S_INS_RD    = 17'b00000000100000000,
    S_INS_WR    = 17'b00000001000000000,
    S_Q_RD      = 17'b00000010000000000,
    S_Q_FILL    = 17'b00000100000000000,
    S_Q_SLOT    = 17'b00001000000000000,
    S_Q_ENT     = 17'b00010000000000000,
    S_Q_CMP     = 17'b00100000000000000,
    S_Q_EMIT    = 17'b01000000000000000,
    S_EMIT      = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = KIND_DONE;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load = 1'b1;
          case (stat.act)
            ACT_CLEAR:  state_nxt = S_CLEAR;
            ACT_INSERT: state_nxt = S_DIV_GO;
            ACT_QUERY:  state_nxt = S_DIV_GO;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_grid = 1'b1;
        cmd.set_kind = 1'b1;
        cmd.kind     = KIND_CLEARED;
        state_nxt    = S_EMIT;
      end
      S_DIV_GO: begin
        if (stat.ts_zero) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = KIND_OOB;
          state_nxt    = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_capture = 1'b1;
          state_nxt = stat.div_last ? S_CHECK : S_DIV_GO;
        end
      end
      S_CHECK: begin
        if (stat.oob) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = KIND_OOB;
          state_nxt    = S_EMIT;
        end else if (stat.is_insert) begin
          if (stat.id_full) begin
            cmd.set_kind = 1'b1;
            cmd.kind     = KIND_FULL;
            state_nxt    = S_EMIT;
          end else begin
            cmd.walk_init = 1'b1;
            state_nxt = stat.walk_empty ? S_INS_ENTRY : S_FCHK_RD;
          end
        end else begin
          cmd.seen_clr  = 1'b1;
          cmd.walk_init = 1'b1;
          if (stat.walk_empty) begin
            cmd.set_kind = 1'b1;
            cmd.kind     = KIND_DONE;
            state_nxt    = S_EMIT;
          end else begin
            state_nxt = S_Q_RD;
          end
        end
      end
      S_FCHK_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_FCHK_CMP;
      end
      S_FCHK_CMP: begin
        if (stat.fill_full) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = KIND_FULL;
          state_nxt    = S_EMIT;
        end else begin
          cmd.walk_next = 1'b1;
          state_nxt = stat.walk_last ? S_INS_ENTRY : S_FCHK_RD;
        end
      end
      S_INS_ENTRY: begin
        cmd.ins_entry = 1'b1;
        cmd.walk_init = 1'b1;
        if (stat.walk_empty) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = KIND_INSERTED;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr    = 1'b1;
        cmd.walk_next = 1'b1;
        if (stat.walk_last) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = KIND_INSERTED;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_Q_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_Q_FILL;
      end
      S_Q_FILL: begin
        cmd.fill_latch = 1'b1;
        state_nxt      = S_Q_SLOT;
      end
      S_Q_SLOT: begin
        if (stat.slot_end) begin
          cmd.walk_next = 1'b1;
          if (stat.walk_last) begin
            cmd.set_kind = 1'b1;
            cmd.kind     = KIND_DONE;
            state_nxt    = S_EMIT;
          end else begin
            state_nxt = S_Q_RD;
          end
        end else begin
          cmd.slot_rd = 1'b1;
          state_nxt   = S_Q_ENT;
        end
      end
      S_Q_ENT: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (stat.hit) begin
          cmd.seen_set = 1'b1;
          state_nxt    = S_Q_EMIT;
        end else begin
          state_nxt = S_Q_SLOT;
        end
      end
      S_Q_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_hit  = 1'b1;
          state_nxt    = S_Q_SLOT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/uniform_grid_box_broadphase.sv]
// ----------------------------------------------------------------------------
// uniform_grid_box_broadphase
// Uniform grid of tiles holding box ids for collision broadphase.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_if (valid/ready); each gives one or more result
// items on out_if, the final one with last set. Configuration is written on
// cfg_we/cfg_index/cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce. An insert or query first
// runs six divisions on one shared serial divider (tile counts and four
// corner tiles), each a start, 18 iterations and a capture. Then an insert
// checks the fill of each covered tile and, if none is full, writes its id
// into each; a query reads the fill of each covered tile, then reads and
// compares each stored slot and emits each hit. One item is worked at a
// time; the next is taken once the final result sits in the output register.
// Reset (rst_n low, synchronous) empties all tiles, restarts ids and loads the
// default layout. A stalled receiver holds the block in place: the result
// register keeps its item and the walk waits until it is taken.
// ----------------------------------------------------------------------------
module uniform_grid_box_broadphase import ugb_pkg::*; #(
  parameter int TILES_X        = TILES_X_DEF,
  parameter int TILES_Y        = TILES_Y_DEF,
  parameter int SLOTS_PER_TILE = SLOTS_PER_TILE_DEF,
  parameter int MAX_ENTRIES    = MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ugb_in_if.sink                in_if,
  ugb_out_if.source             out_if
);

  ugb_cmd_t  cmd;
  ugb_stat_t stat;
  kind_t     out_kind;

  // sequencer
  ugb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // grid datapath
  ugb_datapath #(
    .TILES_X        (TILES_X),
    .TILES_Y        (TILES_Y),
    .SLOTS_PER_TILE (SLOTS_PER_TILE),
    .MAX_ENTRIES    (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_if.valid),
    .in_action     (in_if.action),
    .in_box_min_x  (in_if.box_min_x),
    .in_box_min_y  (in_if.box_min_y),
    .in_box_max_x  (in_if.box_max_x),
    .in_box_max_y  (in_if.box_max_y),
    .in_tag        (in_if.tag),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_kind      (out_kind),
    .out_entry_id  (out_if.entry_id),
    .out_hit_min_x (out_if.hit_min_x),
    .out_hit_min_y (out_if.hit_min_y),
    .out_hit_max_x (out_if.hit_max_x),
    .out_hit_max_y (out_if.hit_max_y),
    .out_hit_tag   (out_if.hit_tag),
    .out_last      (out_if.last)
  );

  assign in_if.ready = cmd.in_ready;
  assign out_if.kind = out_kind;

`ifndef ASSERT_OFF
  // a new item never lands on a running division
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> !stat.div_busy)
    else $error("item accepted while divider busy");

  // an inserted result always carries a nonzero id
  a_insert_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_INSERTED) |-> (out_if.entry_id != '0))
    else $error("inserted result with id zero");

  // hits are never the final result of a query
  a_hit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_HIT) |-> !out_if.last)
    else $error("hit result marked last");

  // reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid after reset");
`endif

endmodule
